// ===== design/lfk_pkg.sv =====
// Package for the Laplacian force kernel: sizes, lane types, sideband struct.
// No dependencies.
`default_nettype none
package lfk_pkg;
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 30;
  localparam int FORCE_W    = 32;
  localparam int D_W        = COORD_BITS + 1;
  localparam int SQ_W       = 2 * D_W;
  localparam int R2_W       = SQ_W + 2;
  localparam int QW         = 2 * FRAC_BITS + 1;
  localparam int RT_W       = FRAC_BITS + 1;
  localparam int SQ_STEPS   = FRAC_BITS + 1;
  localparam int X_W        = 2 * SQ_STEPS;
  localparam int REM_W      = RT_W + 2;

  typedef logic [2:0][SQ_W-1:0] sq3_t;
  typedef logic [2:0][R2_W-1:0] rem3_t;
  typedef logic [2:0][QW-1:0]   quo3_t;
  typedef logic [2:0][RT_W-1:0] rt3_t;

  typedef struct packed {
    logic            excluded;
    logic [2:0]      neg;
    logic [R2_W-1:0] r2;
  } side_t;
endpackage
`default_nettype wire

// ===== design/lfk_front.sv =====
// Front end: differences, magnitudes, squares and r2 over three stages.
// Uses lfk_pkg.
`default_nettype none
module lfk_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] obs_x,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] obs_y,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] obs_z,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] src_x,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] src_y,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] src_z,
  output logic                                 out_valid,
  output lfk_pkg::side_t                       out_side,
  output lfk_pkg::sq3_t                        out_sq
);
  logic [2:0] v;
  logic signed [lfk_pkg::D_W-1:0] d [3];
  logic [2:0][lfk_pkg::D_W-1:0] mag;
  logic [2:0] neg_a, neg_b;
  logic [2:0][lfk_pkg::D_W-1:0] mag_r;
  lfk_pkg::sq3_t sq_r;
  lfk_pkg::sq3_t sq_c;

  always_comb begin
    d[0] = lfk_pkg::D_W'(src_x) - lfk_pkg::D_W'(obs_x);
    d[1] = lfk_pkg::D_W'(src_y) - lfk_pkg::D_W'(obs_y);
    d[2] = lfk_pkg::D_W'(src_z) - lfk_pkg::D_W'(obs_z);
    for (int i = 0; i < 3; i++) begin
      mag[i] = d[i][lfk_pkg::D_W-1] ? lfk_pkg::D_W'(-d[i]) : lfk_pkg::D_W'(d[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= d[i][lfk_pkg::D_W-1];
        mag_r[i] <= mag[i];
        sq_r[i]  <= lfk_pkg::SQ_W'(mag_r[i]) * lfk_pkg::SQ_W'(mag_r[i]);
      end
      neg_b <= neg_a;
      sq_c  <= sq_r;
      out_side.neg <= neg_b;
      out_side.r2  <= lfk_pkg::R2_W'(sq_r[0]) + lfk_pkg::R2_W'(sq_r[1])
                    + lfk_pkg::R2_W'(sq_r[2]);
      out_side.excluded <= (sq_r[0] == '0) && (sq_r[1] == '0) && (sq_r[2] == '0);
    end
  end

  assign out_valid = v[2];
  assign out_sq    = sq_c;
endmodule
`default_nettype wire

// ===== design/lfk_div.sv =====
// Restoring divider by r2, one quotient bit per stage, three lanes.
// Uses lfk_pkg.
`default_nettype none
module lfk_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lfk_pkg::side_t in_side,
  input  lfk_pkg::rem3_t in_rem,
  input  lfk_pkg::quo3_t in_stream,
  output logic           out_valid,
  output lfk_pkg::side_t out_side,
  output lfk_pkg::quo3_t out_quo
);
  localparam int N = lfk_pkg::QW;
  logic           v    [N];
  lfk_pkg::side_t side [N];
  lfk_pkg::rem3_t rem  [N];
  lfk_pkg::quo3_t str  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           sv;
    lfk_pkg::side_t ss;
    lfk_pkg::rem3_t sr, rn;
    lfk_pkg::quo3_t sq, qn;
    logic [lfk_pkg::R2_W:0] t [3];
    if (k == 0) begin : g_in
      assign sv = in_valid;
      assign ss = in_side;
      assign sr = in_rem;
      assign sq = in_stream;
    end else begin : g_mid
      assign sv = v[k-1];
      assign ss = side[k-1];
      assign sr = rem[k-1];
      assign sq = str[k-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i] = {sr[i], sq[i][N-1]};
        if (t[i] >= {1'b0, ss.r2}) begin
          rn[i] = lfk_pkg::R2_W'(t[i] - {1'b0, ss.r2});
          qn[i] = {sq[i][N-2:0], 1'b1};
        end else begin
          rn[i] = lfk_pkg::R2_W'(t[i]);
          qn[i] = {sq[i][N-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= sv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= ss;
        rem[k]  <= rn;
        str[k]  <= qn;
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_side  = side[N-1];
  assign out_quo   = str[N-1];
endmodule
`default_nettype wire

// ===== design/lfk_sqrt.sv =====
// Digit-by-digit integer square root, one root bit per stage, three lanes.
// Uses lfk_pkg.
`default_nettype none
module lfk_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  lfk_pkg::side_t in_side,
  input  lfk_pkg::quo3_t in_x,
  output logic           out_valid,
  output lfk_pkg::side_t out_side,
  output lfk_pkg::rt3_t  out_root
);
  localparam int N = lfk_pkg::SQ_STEPS;
  localparam int XW = lfk_pkg::X_W;
  localparam int RW = lfk_pkg::REM_W;
  typedef logic [2:0][RW-1:0] srem3_t;
  typedef logic [2:0][XW-1:0] x3_t;
  logic           v    [N];
  lfk_pkg::side_t side [N];
  srem3_t         rem  [N];
  lfk_pkg::rt3_t  root [N];
  x3_t            xs   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic           sv;
    lfk_pkg::side_t ss;
    srem3_t         sr, rn;
    lfk_pkg::rt3_t  st, tn;
    x3_t            sx, xn;
    logic [RW+1:0]  rr [3];
    logic [RW+1:0]  trial [3];
    if (k == 0) begin : g_in
      assign sv = in_valid;
      assign ss = in_side;
      assign sr = '0;
      assign st = '0;
      always_comb begin
        for (int i = 0; i < 3; i++) sx[i] = XW'(in_x[i]);
      end
    end else begin : g_mid
      assign sv = v[k-1];
      assign ss = side[k-1];
      assign sr = rem[k-1];
      assign st = root[k-1];
      assign sx = xs[k-1];
    end
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rr[i]    = {sr[i], sx[i][XW-1:XW-2]};
        trial[i] = (RW + 2)'({st[i], 2'b01});
        xn[i]    = {sx[i][XW-3:0], 2'b00};
        if (rr[i] >= trial[i]) begin
          rn[i] = RW'(rr[i] - trial[i]);
          tn[i] = {st[i][lfk_pkg::RT_W-2:0], 1'b1};
        end else begin
          rn[i] = RW'(rr[i]);
          tn[i] = {st[i][lfk_pkg::RT_W-2:0], 1'b0};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= sv;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= ss;
        rem[k]  <= rn;
        root[k] <= tn;
        xs[k]   <= xn;
      end
    end
  end

  assign out_valid = v[N-1];
  assign out_side  = side[N-1];
  assign out_root  = root[N-1];
endmodule
`default_nettype wire

// ===== design/laplacian_force_kernel.sv =====
// Laplacian force kernel: d/r^3 per component in Q2.30, fully pipelined.
// Pipeline: 3 front stages + 3 x 61 divider stages + 31 root stages + 1 output
//   register between input transfer and result valid.
// Throughput: one transfer per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous): clears all valid bits; payload registers are not reset.
// Uses lfk_pkg, lfk_front, lfk_div, lfk_sqrt.
`default_nettype none
module laplacian_force_kernel (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] obs_x,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] obs_y,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] obs_z,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] src_x,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] src_y,
  input  logic signed [lfk_pkg::COORD_BITS-1:0] src_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [lfk_pkg::FORCE_W-1:0]    force_x,
  output logic signed [lfk_pkg::FORCE_W-1:0]    force_y,
  output logic signed [lfk_pkg::FORCE_W-1:0]    force_z,
  output logic                                 excluded
);
  localparam int CW = ((lfk_pkg::RT_W > lfk_pkg::FORCE_W) ?
                       lfk_pkg::RT_W : lfk_pkg::FORCE_W) + 1;

  logic en;
  logic f_v, d1_v, d2_v, d3_v, s_v;
  lfk_pkg::side_t f_s, d1_s, d2_s, d3_s, s_s;
  lfk_pkg::sq3_t  f_sq;
  lfk_pkg::rem3_t d1_rem;
  lfk_pkg::quo3_t d1_str, d1_q, d2_q, d3_q;
  lfk_pkg::rt3_t  root;
  logic [2:0][lfk_pkg::FORCE_W-1:0] fv;

  function automatic logic [lfk_pkg::FORCE_W-1:0] sat_sign(
    input logic [lfk_pkg::RT_W-1:0] r, input logic neg);
    logic [CW-1:0] lim;
    logic [CW-1:0] m;
    lim = (CW'(1) << (lfk_pkg::FORCE_W - 1)) - CW'(!neg);
    m   = (CW'(r) > lim) ? lim : CW'(r);
    m   = neg ? -m : m;
    return m[lfk_pkg::FORCE_W-1:0];
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  lfk_front u_front (
    .clk, .rst, .en, .in_valid,
    .obs_x, .obs_y, .obs_z, .src_x, .src_y, .src_z,
    .out_valid(f_v), .out_side(f_s), .out_sq(f_sq)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1_rem[i] = lfk_pkg::R2_W'(f_sq[i] >> 1);
      d1_str[i] = lfk_pkg::QW'(f_sq[i][0]) << (lfk_pkg::QW - 1);
    end
  end

  lfk_div u_div1 (
    .clk, .rst, .en, .in_valid(f_v), .in_side(f_s), .in_rem(d1_rem),
    .in_stream(d1_str), .out_valid(d1_v), .out_side(d1_s), .out_quo(d1_q)
  );

  lfk_div u_div2 (
    .clk, .rst, .en, .in_valid(d1_v), .in_side(d1_s), .in_rem('0),
    .in_stream(d1_q), .out_valid(d2_v), .out_side(d2_s), .out_quo(d2_q)
  );

  lfk_div u_div3 (
    .clk, .rst, .en, .in_valid(d2_v), .in_side(d2_s), .in_rem('0),
    .in_stream(d2_q), .out_valid(d3_v), .out_side(d3_s), .out_quo(d3_q)
  );

  lfk_sqrt u_sqrt (
    .clk, .rst, .en, .in_valid(d3_v), .in_side(d3_s), .in_x(d3_q),
    .out_valid(s_v), .out_side(s_s), .out_root(root)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fv[i] = s_s.excluded ? '0 : sat_sign(root[i], s_s.neg[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x  <= fv[0];
      force_y  <= fv[1];
      force_z  <= fv[2];
      excluded <= s_s.excluded;
    end
  end

  a_excl_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && excluded |-> force_x == '0 && force_y == '0 && force_z == '0)
    else $error("excluded result with nonzero force");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> force_x <= (1 <<< lfk_pkg::FRAC_BITS) &&
                  force_x >= -(1 <<< lfk_pkg::FRAC_BITS))
    else $error("force_x out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_y) && $stable(excluded))
    else $error("stalled result not held");
endmodule
`default_nettype wire
